// ===== design/hsv_to_rgb_converter_unit_defines.svh =====
// Assertion macros for the checker file of the HSV to RGB converter.
// Needs a clk_i, and for HSVRGB_ASSERT an active-low rst_ni, in the scope where a macro is used.
`ifndef HSV_TO_RGB_CONVERTER_UNIT_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_UNIT_DEFINES_SVH

// Checked on every rising edge outside of reset.
`define HSVRGB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every rising edge, reset included.
`define HSVRGB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/hsvrgb_pkg.sv =====
// Shared widths, constants, types and helpers of the HSV to RGB converter.
// No dependencies; used by the top level and its checker.
package hsvrgb_pkg;

  localparam int HueW     = 10;
  localparam int SvW      = 11;
  localparam int ChanW    = 8;
  localparam int NumChan  = 3;
  localparam int InDataW  = 32;
  localparam int OutDataW = 24;

  localparam logic [HueW-1:0] HueTurn = 10'd360;
  localparam int SectorDeg = 60;
  localparam int RemW      = 6;
  localparam int CntW      = 4;
  localparam int NumCnt    = 11;

  localparam int ZW         = 12;
  localparam int RecipW     = 13;
  localparam int RecipMul   = 4370;
  localparam int RecipShift = 16;
  localparam int QuotW      = 9;

  typedef enum logic [2:0] {
    SectorRY,
    SectorYG,
    SectorGC,
    SectorCB,
    SectorBM,
    SectorMR
  } sector_e;

  function automatic logic [HueW-1:0] sector_base(input logic [CntW-1:0] cnt);
    logic [HueW-1:0] c;
    c = HueW'(cnt);
    return (c << 6) - (c << 2);
  endfunction

endpackage

// ===== design/hsv_to_rgb_converter_unit.sv =====
// HSV to RGB converter, six-stage pipeline with per-stage valid bits.
// Depends on hsvrgb_pkg for widths, the sector type and the sector bases.
//
// Usage: one color enters as a transfer on the s_axis channel and one RGB
// result leaves as a transfer on the m_axis channel, in the same order.
// s_axis_tdata holds hue (degrees), saturation and value (units of
// 1/2**FRACTION_BITS, clamped to 1.0); m_axis_tdata holds red, green, blue.
// Throughput is one color per cycle while m_axis_tready stays high; the six
// register stages (hue wrap, sector search, term build, value multiply,
// scale by 255, divide by 60) each take a new item every cycle in which
// they advance.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles are squeezed out while the receiver stalls. A stalled result
// holds in the output register; s_axis_tready falls only when all six
// stages hold an item and m_axis_tready is low.
// Reset clears all valid bits; the block is ready for input right after.
module hsv_to_rgb_converter_unit #(
  parameter int FRACTION_BITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // hue[9:0], saturation[20:10], brightness[31:21]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);

  localparam int HueW  = hsvrgb_pkg::HueW;
  localparam int SvW   = hsvrgb_pkg::SvW;
  localparam int ChanW = hsvrgb_pkg::ChanW;
  localparam int NC    = hsvrgb_pkg::NumChan;
  localparam int RemW  = hsvrgb_pkg::RemW;
  localparam int CntW  = hsvrgb_pkg::CntW;
  localparam int ZW    = hsvrgb_pkg::ZW;
  localparam int QW    = hsvrgb_pkg::ZW + hsvrgb_pkg::RecipW;
  localparam int QuotW = hsvrgb_pkg::QuotW;

  localparam int OneW = FRACTION_BITS + 1;
  localparam int CmpW = (OneW > SvW) ? OneW : SvW;
  localparam logic [CmpW-1:0] OneCmp = {{(CmpW-1){1'b0}}, 1'b1} << FRACTION_BITS;
  localparam logic [SvW-1:0] OneSv = OneCmp[SvW-1:0];
  localparam int XW = FRACTION_BITS + 6;
  localparam logic [XW-1:0] SixtyOne = XW'(hsvrgb_pkg::SectorDeg) << FRACTION_BITS;
  localparam int PW  = 2 * FRACTION_BITS + 6;
  localparam int SW  = PW + 8;
  localparam int ZLo = 2 * FRACTION_BITS + 2;

  logic en1, en2, en3, en4, en5, en6;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic v1_d, v2_d, v3_d, v4_d, v5_d, v6_d;

  logic [HueW-1:0] hue_in, h1_d, h1_q;
  logic [SvW-1:0]  sat_in, bri_in;
  logic [SvW-1:0]  s1_d, s1_q, b1_d, b1_q;

  logic [CntW-1:0]     cnt;
  hsvrgb_pkg::sector_e sec2_d, sec2_q;
  logic [RemW-1:0]     rem2_d, rem2_q;
  logic [SvW-1:0]      s2_q, b2_q;

  logic [XW-1:0]          sr, st, xp, xq, xt;
  logic [NC-1:0][XW-1:0]  x3_d, x3_q;
  logic [SvW-1:0]         b3_q;

  logic [NC-1:0][PW-1:0]   p4_d, p4_q;
  logic [NC-1:0][SW-1:0]   scl;
  logic [NC-1:0][ZW-1:0]   z5_d, z5_q;
  logic [NC-1:0][QW-1:0]   prod;
  logic [NC-1:0][QuotW-1:0] quot;
  logic [NC-1:0][ChanW-1:0] rgb6_d, rgb6_q;

  assign en6 = !v6_q || m_axis_tready;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign s_axis_tready = en1;
  assign m_axis_tvalid = v6_q;
  assign m_axis_tdata  = rgb6_q;

  assign v1_d = en1 ? s_axis_tvalid : v1_q;
  assign v2_d = en2 ? v1_q : v2_q;
  assign v3_d = en3 ? v2_q : v3_q;
  assign v4_d = en4 ? v3_q : v4_q;
  assign v5_d = en5 ? v4_q : v5_q;
  assign v6_d = en6 ? v5_q : v6_q;

  assign hue_in = s_axis_tdata[HueW-1:0];
  assign sat_in = s_axis_tdata[HueW+SvW-1:HueW];
  assign bri_in = s_axis_tdata[HueW+2*SvW-1:HueW+SvW];

  always_comb begin
    h1_d = (hue_in > hsvrgb_pkg::HueTurn) ? hue_in - hsvrgb_pkg::HueTurn : hue_in;
    if (h1_d == hsvrgb_pkg::HueTurn) begin
      h1_d = '0;
    end
    s1_d = (CmpW'(sat_in) > OneCmp) ? OneSv : sat_in;
    b1_d = (CmpW'(bri_in) > OneCmp) ? OneSv : bri_in;
  end

  always_comb begin
    cnt = '0;
    for (int k = 1; k <= hsvrgb_pkg::NumCnt; k++) begin
      if (h1_q >= hsvrgb_pkg::sector_base(CntW'(k))) begin
        cnt = CntW'(k);
      end
    end
    rem2_d = RemW'(h1_q - hsvrgb_pkg::sector_base(cnt));
    sec2_d = (cnt >= CntW'(hsvrgb_pkg::SectorMR)) ? hsvrgb_pkg::SectorMR
                                                  : hsvrgb_pkg::sector_e'(cnt[2:0]);
  end

  always_comb begin
    sr = XW'(s2_q) * XW'(rem2_q);
    st = XW'(s2_q) * XW'(RemW'(hsvrgb_pkg::SectorDeg) - rem2_q);
    xp = SixtyOne - ((XW'(s2_q) << 6) - (XW'(s2_q) << 2));
    xq = SixtyOne - sr;
    xt = SixtyOne - st;
    unique case (sec2_q)
      hsvrgb_pkg::SectorRY: x3_d = {xp, xt, SixtyOne};
      hsvrgb_pkg::SectorYG: x3_d = {xp, SixtyOne, xq};
      hsvrgb_pkg::SectorGC: x3_d = {xt, SixtyOne, xp};
      hsvrgb_pkg::SectorCB: x3_d = {SixtyOne, xq, xp};
      hsvrgb_pkg::SectorBM: x3_d = {SixtyOne, xp, xt};
      default:              x3_d = {xq, xp, SixtyOne};
    endcase
  end

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      p4_d[c]   = PW'(b3_q) * PW'(x3_q[c]);
      scl[c]    = (SW'(p4_q[c]) << 8) - SW'(p4_q[c]);
      z5_d[c]   = scl[c][ZLo+ZW-1:ZLo];
      prod[c]   = QW'(z5_q[c]) * QW'(hsvrgb_pkg::RecipMul);
      quot[c]   = prod[c][hsvrgb_pkg::RecipShift+QuotW-1:hsvrgb_pkg::RecipShift];
      rgb6_d[c] = (quot[c] > QuotW'(8'hFF)) ? 8'hFF : quot[c][ChanW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      v4_q <= v4_d;
      v5_q <= v5_d;
      v6_q <= v6_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      h1_q <= h1_d;
      s1_q <= s1_d;
      b1_q <= b1_d;
    end
    if (en2) begin
      sec2_q <= sec2_d;
      rem2_q <= rem2_d;
      s2_q   <= s1_q;
      b2_q   <= b1_q;
    end
    if (en3) begin
      x3_q <= x3_d;
      b3_q <= b2_q;
    end
    if (en4) begin
      p4_q <= p4_d;
    end
    if (en5) begin
      z5_q <= z5_d;
    end
    if (en6) begin
      rgb6_q <= rgb6_d;
    end
  end

endmodule

// ===== design/hsvrgb_checker.sv =====
// Port-level checker of the HSV to RGB converter, bound to its top level.
// Depends on hsvrgb_pkg and hsv_to_rgb_converter_unit_defines.svh.
`include "hsv_to_rgb_converter_unit_defines.svh"

module hsvrgb_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [hsvrgb_pkg::OutDataW-1:0] m_axis_tdata
);

  `HSVRGB_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !m_axis_tvalid, "Result valid during reset.")

  `HSVRGB_ASSERT(a_stall_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "Stalled result changed.")

  `HSVRGB_ASSERT(a_empty_ready, !m_axis_tvalid |-> s_axis_tready, "Input blocked while output register is empty.")

  `HSVRGB_ASSERT(a_block_cause, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "Input blocked without an output stall.")

endmodule

bind hsv_to_rgb_converter_unit hsvrgb_checker u_hsvrgb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
